// ----- hdl/aarm_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the rotation matrix block.
package aarm_pkg;

   typedef struct packed {
      logic signed [15:0] angle;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] col0_row0;
      logic signed [15:0] col0_row1;
      logic signed [15:0] col0_row2;
      logic signed [15:0] col1_row0;
      logic signed [15:0] col1_row1;
      logic signed [15:0] col1_row2;
      logic signed [15:0] col2_row0;
      logic signed [15:0] col2_row1;
      logic signed [15:0] col2_row2;
      logic               axis_zero;
   } rsp_type;

   localparam logic signed [15:0] ANGLE_MAX   = 16'sd25736;
   localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 16;

   // Stage map: index of the register a step reads
   localparam int SQRT_FIRST = 0;
   localparam int CS_STAGE   = CORDIC_STEPS;
   localparam int DIV_FIRST  = SQRT_STEPS;
   localparam int UNIT_STAGE = DIV_FIRST + DIV_STEPS;
   localparam int PROD_STAGE = UNIT_STAGE + 1;
   localparam int SCALE_STAGE = PROD_STAGE + 1;
   localparam int ENTRY_STAGE = SCALE_STAGE + 1;
   localparam int LAST        = ENTRY_STAGE + 1;

   function automatic logic signed [33:0] atan_q30(input logic [3:0] i);
      logic signed [33:0] r;
      case (i)
         4'd0:    r = 34'sh03243F6A8;
         4'd1:    r = 34'sh01DAC6705;
         4'd2:    r = 34'sh00FADBAFC;
         4'd3:    r = 34'sh007F56EA6;
         4'd4:    r = 34'sh003FEAB76;
         4'd5:    r = 34'sh001FFD55B;
         4'd6:    r = 34'sh000FFFAAA;
         4'd7:    r = 34'sh0007FFF55;
         4'd8:    r = 34'sh0003FFFEA;
         4'd9:    r = 34'sh0001FFFFD;
         4'd10:   r = 34'sh0000FFFFF;
         4'd11:   r = 34'sh00007FFFF;
         4'd12:   r = 34'sh00003FFFF;
         4'd13:   r = 34'sh00001FFFF;
         4'd14:   r = 34'sh00000FFFF;
         default: r = 34'sh000007FFF;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/axis_angle_rotation_matrix.sv -----
// Top level: pipelined axis-angle to 3x3 rotation matrix.
//
// req_ carries an angle (Q3.13 radians) and an axis of any length; rsp_
// carries the nine matrix entries, column-major, in Q1.14, plus axis_zero.
// An item is taken at an edge where valid is high and stall is low.
// Throughput is one item per cycle while rsp_stall does not hold the output.
// The result passes through 32 stages of a bit-per-stage square root,
// followed by 16 stages of a bit-per-stage divider for the unit axis and
// four stages of multiply and round before it appears on rsp_. The 16 CORDIC
// rotations run alongside the square root.
// The whole pipeline advances as one: when rsp_valid is high and rsp_stall
// is high every stage holds and req_stall is raised in the same cycle, so
// nothing is lost or repeated.
// Synchronous reset clears all stage valid bits; data registers keep junk
// that is never shown. An all-zero axis returns the identity matrix with
// axis_zero set.
module axis_angle_rotation_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aarm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aarm_pkg::rsp_type rsp_data
);
   import aarm_pkg::*;

   typedef struct {
      logic               zero;
      logic               flip;
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] cz;
      logic        [31:0] ss;
      logic        [35:0] srem;
      logic        [31:0] root;
      logic               sgn  [3];
      logic        [47:0] rem  [3];
      logic        [15:0] q    [3];
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic signed [16:0] cp;
      logic signed [15:0] u    [3];
      logic signed [31:0] pr   [6];
      logic signed [31:0] su   [3];
      logic signed [47:0] tc   [6];
      logic signed [47:0] sc   [3];
      logic signed [47:0] cd;
      rsp_type            res;
   } pipe_type;

   pipe_type            pipe_ff [LAST+1];
   pipe_type            pipe_in [LAST+1];
   logic     [LAST:0]   vld_ff;
   logic                adv;

   function automatic pipe_type first_stage(input req_type d);
      pipe_type           n;
      logic signed [15:0] a;
      logic signed [33:0] z;
      logic signed [31:0] px, py, pz;
      logic        [15:0] mg [3];
      logic signed [15:0] ax [3];
      n = '{default: '0};
      a = d.angle;
      if (a > ANGLE_MAX) a = ANGLE_MAX;
      if (a < -ANGLE_MAX) a = -ANGLE_MAX;
      z = 34'(a);
      z = z <<< 17;
      n.flip = 1'b0;
      if (z > HALF_PI_Q30) begin
         z = z - PI_Q30;
         n.flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
         z = z + PI_Q30;
         n.flip = 1'b1;
      end
      n.cx = CORDIC_GAIN;
      n.cy = '0;
      n.cz = z;
      px = d.axis_x * d.axis_x;
      py = d.axis_y * d.axis_y;
      pz = d.axis_z * d.axis_z;
      n.ss = unsigned'(px) + unsigned'(py) + unsigned'(pz);
      n.srem = '0;
      n.root = '0;
      ax[0] = d.axis_x;
      ax[1] = d.axis_y;
      ax[2] = d.axis_z;
      for (int i = 0; i < 3; i++) begin
         mg[i] = ax[i][15] ? 16'(-ax[i]) : 16'(ax[i]);
         n.sgn[i] = ax[i][15];
         n.rem[i] = {1'b0, mg[i], 31'b0};
         n.q[i] = '0;
      end
      n.zero = (d.axis_x == 16'sd0) && (d.axis_y == 16'sd0) && (d.axis_z == 16'sd0);
      return n;
   endfunction

   function automatic logic signed [15:0] round_entry(input logic signed [47:0] v);
      logic signed [47:0] t;
      logic signed [15:0] r;
      t = (v + 48'sd134217728) >>> 28;
      if (t > 48'sd16384) r = ONE_Q14;
      else if (t < -48'sd16384) r = -ONE_Q14;
      else r = t[15:0];
      return r;
   endfunction

   function automatic pipe_type next_stage(input pipe_type p, input int k);
      pipe_type           n;
      logic signed [33:0] dx, dy, xv, t;
      logic        [31:0] sh;
      logic        [35:0] r, trial;
      logic        [47:0] dsh;
      logic        [16:0] qr;
      logic signed [48:0] wide;
      logic signed [16:0] cc;
      int                 j;
      n = p;
      // CORDIC rotation, one per stage
      if (k < CORDIC_STEPS) begin
         dx = p.cy >>> k;
         dy = p.cx >>> k;
         if (!p.cz[33]) begin
            n.cx = p.cx - dx;
            n.cy = p.cy + dy;
            n.cz = p.cz - atan_q30(4'(k));
         end else begin
            n.cx = p.cx + dx;
            n.cy = p.cy - dy;
            n.cz = p.cz + atan_q30(4'(k));
         end
      end
      if (k == CS_STAGE) begin
         xv = p.flip ? -p.cx : p.cx;
         t = (xv + 34'sd32768) >>> 16;
         if (t > 34'sd16384) n.c = ONE_Q14;
         else if (t < -34'sd16384) n.c = -ONE_Q14;
         else n.c = t[15:0];
         xv = p.flip ? -p.cy : p.cy;
         t = (xv + 34'sd32768) >>> 16;
         if (t > 34'sd16384) n.s = ONE_Q14;
         else if (t < -34'sd16384) n.s = -ONE_Q14;
         else n.s = t[15:0];
      end
      // Square root of ss * 2^32, one root bit per stage
      if (k >= SQRT_FIRST && k < SQRT_FIRST + SQRT_STEPS) begin
         j = k - SQRT_FIRST;
         sh = (j < 16) ? (p.ss >> (30 - 2 * j)) : 32'd0;
         r = {p.srem[33:0], sh[1:0]};
         trial = {2'b00, p.root, 2'b01};
         if (r >= trial) begin
            n.srem = r - trial;
            n.root = {p.root[30:0], 1'b1};
         end else begin
            n.srem = r;
            n.root = {p.root[30:0], 1'b0};
         end
      end
      // Restoring division by the root, one quotient bit per stage
      if (k >= DIV_FIRST && k < DIV_FIRST + DIV_STEPS) begin
         j = DIV_FIRST + DIV_STEPS - 1 - k;
         dsh = {16'b0, p.root} << j;
         for (int i = 0; i < 3; i++) begin
            if (p.rem[i] >= dsh) begin
               n.rem[i] = p.rem[i] - dsh;
               n.q[i] = p.q[i] | (16'd1 << j);
            end
         end
      end
      if (k == UNIT_STAGE) begin
         for (int i = 0; i < 3; i++) begin
            qr = ({1'b0, p.q[i]} + 17'd1) >> 1;
            if (qr > 17'd16384) qr = 17'd16384;
            n.u[i] = p.sgn[i] ? -signed'(qr[15:0]) : signed'(qr[15:0]);
         end
         cc = 17'(p.c);
         n.cp = 17'sd16384 - cc;
      end
      if (k == PROD_STAGE) begin
         n.pr[0] = p.u[0] * p.u[0];
         n.pr[1] = p.u[1] * p.u[1];
         n.pr[2] = p.u[2] * p.u[2];
         n.pr[3] = p.u[0] * p.u[1];
         n.pr[4] = p.u[0] * p.u[2];
         n.pr[5] = p.u[1] * p.u[2];
         for (int i = 0; i < 3; i++) n.su[i] = p.s * p.u[i];
      end
      if (k == SCALE_STAGE) begin
         for (int i = 0; i < 6; i++) begin
            wide = p.cp * p.pr[i];
            n.tc[i] = wide[47:0];
         end
         for (int i = 0; i < 3; i++) begin
            n.sc[i] = 48'(p.su[i]);
            n.sc[i] = n.sc[i] <<< 14;
         end
         n.cd = 48'(p.c);
         n.cd = n.cd <<< 28;
      end
      if (k == ENTRY_STAGE) begin
         if (p.zero) begin
            n.res = '0;
            n.res.col0_row0 = ONE_Q14;
            n.res.col1_row1 = ONE_Q14;
            n.res.col2_row2 = ONE_Q14;
            n.res.axis_zero = 1'b1;
         end else begin
            n.res.col0_row0 = round_entry(p.cd + p.tc[0]);
            n.res.col0_row1 = round_entry(p.tc[3] + p.sc[2]);
            n.res.col0_row2 = round_entry(p.tc[4] - p.sc[1]);
            n.res.col1_row0 = round_entry(p.tc[3] - p.sc[2]);
            n.res.col1_row1 = round_entry(p.cd + p.tc[1]);
            n.res.col1_row2 = round_entry(p.tc[5] + p.sc[0]);
            n.res.col2_row0 = round_entry(p.tc[4] + p.sc[1]);
            n.res.col2_row1 = round_entry(p.tc[5] - p.sc[0]);
            n.res.col2_row2 = round_entry(p.cd + p.tc[2]);
            n.res.axis_zero = 1'b0;
         end
      end
      return n;
   endfunction

   // Hold every stage while the last one waits on the receiver
   assign adv       = !(vld_ff[LAST] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = pipe_ff[LAST].res;

   always_comb begin
      pipe_in[0] = first_stage(req_data);
      for (int k = 0; k < LAST; k++) pipe_in[k+1] = next_stage(pipe_ff[k], k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= LAST; k++) pipe_ff[k] <= pipe_in[k];
      end
   end

endmodule

// ----- hdl/aarm_checker.sv -----
// Port-level checks for the rotation matrix block, bound to the top level.
module aarm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input aarm_pkg::rsp_type rsp_data
);
   import aarm_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed or dropped");

   // Input backs up only when the output is blocked
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output blocking");

   a_zero_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.axis_zero |->
         rsp_data.col0_row0 == ONE_Q14 && rsp_data.col1_row1 == ONE_Q14 &&
         rsp_data.col2_row2 == ONE_Q14 && rsp_data.col0_row1 == 16'sd0 &&
         rsp_data.col1_row0 == 16'sd0 && rsp_data.col2_row0 == 16'sd0)
      else $error("zero axis without identity");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item shown right after reset");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (.*);

// ----- tb/sv/axis_angle_rotation_matrix_checker.sv -----
// Checker: watches both channels, predicts each rotation matrix and compares.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  aarm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  aarm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                matrices_seen,
   output int                zero_axes_seen
);
   import aarm_pkg::*;

   rsp_type matrix_queue[$];

   function automatic longint fshift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint clamp_q14(input longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint round_entry(input longint v);
      return clamp_q14(fshift(v + (64'sd1 <<< 27), 28));
   endfunction

   function automatic longint int_sqrt(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint unit_axis(input longint a, input longint d);
      longint m, q;
      m = (a < 0) ? -a : a;
      q = ((m <<< 31) / d + 1) >>> 1;
      if (q > 16384) q = 16384;
      return (a < 0) ? -q : q;
   endfunction

   function automatic rsp_type predict_matrix(input req_type r);
      rsp_type o;
      longint ang, ax, ay, az, z, x, y, dx, dy, c, s, cp, ux, uy, uz, d;
      logic [63:0] ss;
      bit flip;
      ang = longint'(r.angle);
      ax = longint'(r.axis_x);
      ay = longint'(r.axis_y);
      az = longint'(r.axis_z);
      o = '0;
      if (ang > 25736) ang = 25736;
      if (ang < -25736) ang = -25736;
      if (ax == 0 && ay == 0 && az == 0) begin
         o.col0_row0 = ONE_Q14;
         o.col1_row1 = ONE_Q14;
         o.col2_row2 = ONE_Q14;
         o.axis_zero = 1'b1;
         return o;
      end
      z = ang * 131072;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 1686629713) begin
         z -= 64'sd3373259426;
         flip = 1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(4'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_q30(4'(i)));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_q14(fshift(x + 32768, 16));
      s = clamp_q14(fshift(y + 32768, 16));
      cp = 16384 - c;
      ss = ax * ax + ay * ay + az * az;
      d = int_sqrt(ss << 32);
      ux = unit_axis(ax, d);
      uy = unit_axis(ay, d);
      uz = unit_axis(az, d);
      o.col0_row0 = 16'(round_entry(c * 268435456 + cp * ux * ux));
      o.col0_row1 = 16'(round_entry(cp * ux * uy + s * uz * 16384));
      o.col0_row2 = 16'(round_entry(cp * ux * uz - s * uy * 16384));
      o.col1_row0 = 16'(round_entry(cp * ux * uy - s * uz * 16384));
      o.col1_row1 = 16'(round_entry(c * 268435456 + cp * uy * uy));
      o.col1_row2 = 16'(round_entry(cp * uy * uz + s * ux * 16384));
      o.col2_row0 = 16'(round_entry(cp * ux * uz + s * uy * 16384));
      o.col2_row1 = 16'(round_entry(cp * uy * uz - s * ux * 16384));
      o.col2_row2 = 16'(round_entry(c * 268435456 + cp * uz * uz));
      return o;
   endfunction

   assign pending = matrix_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         matrices_seen <= 0;
         zero_axes_seen <= 0;
      end else begin
         if (req_valid && !req_stall)
            matrix_queue.push_back(predict_matrix(req_data));
         if (rsp_valid && !rsp_stall) begin
            matrices_seen <= matrices_seen + 1;
            if (rsp_data.axis_zero) zero_axes_seen <= zero_axes_seen + 1;
            if (matrix_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected matrix %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = matrix_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("matrix mismatch: expected %h got %h", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- tb/sv/axis_angle_rotation_matrix_tb.sv -----
// Testbench top: drives rotation requests, stalls results and gives the verdict.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;
   import aarm_pkg::*;

   logic    clock = 0, reset = 1;
   logic    req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   int      fail_count, pending, matrices_seen, zero_axes_seen;
   int      send_idle_pct = 0, stall_pct = 0;

   axis_angle_rotation_matrix uut (.*);
   axis_angle_rotation_matrix_checker chk (.*);

   initial forever #4 clock = ~clock;

   initial begin
      #20ms;
      $display("axis_angle_rotation_matrix regression: fail");
      $finish;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic logic [15:0] rand_field();
      case ($urandom_range(5))
         0: return 16'(16'sh7FFF - $urandom_range(3));
         1: return 16'(16'sh8000 + $urandom_range(3));
         2: return 16'($urandom_range(4) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_rotation(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic random_rotation();
      req_type r;
      r.angle = ($urandom_range(3) == 0) ? rand_field()
                : 16'($signed($urandom_range(51472)) - 25736);
      r.axis_x = rand_field();
      r.axis_y = rand_field();
      r.axis_z = rand_field();
      if ($urandom_range(30) == 0) {r.axis_x, r.axis_y, r.axis_z} = '0;
      send_rotation(r);
   endtask

   initial begin
      int wait_cycles;
      repeat (8) @(posedge clock);
      reset <= 0;
      // directed: angle extremes, saturation, zero axis, axis extremes
      send_rotation('{16'sd0, 16'sd1, 16'sd0, 16'sd0});
      send_rotation('{16'sd25736, 16'sd0, 16'sd0, 16'sd1});
      send_rotation('{-16'sd25736, 16'sd0, 16'sd1, 16'sd0});
      send_rotation('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
      send_rotation('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      send_rotation('{16'sd25737, -16'sd1, 16'sd2, -16'sd3});
      send_rotation('{16'sd12868, 16'sh8000, 16'sd0, 16'sd0});
      send_rotation('{-16'sd12869, 16'sd0, 16'sh7FFF, 16'sh8000});
      send_rotation('{16'sd12868, 16'sd0, 16'sd0, 16'sd0});
      send_rotation('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
      send_rotation('{16'sd1, 16'sd3, 16'sd4, 16'sd12});
      send_rotation('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_rotation('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
      send_rotation('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
      // hold off until the pipe drains
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin send_idle_pct = 77; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 77; end
            3: begin send_idle_pct = 31; stall_pct = 31; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         repeat (287) random_rotation();
      end
      req_valid <= 0;
      @(posedge clock);
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      stall_pct = 0;
      repeat (120) @(posedge clock);
      $display("covered %0d matrices, %0d with a zero axis, under varied idle and stall",
               matrices_seen, zero_axes_seen);
      if (fail_count == 0 && pending == 0)
         $display("axis_angle_rotation_matrix regression: pass");
      else
         $display("axis_angle_rotation_matrix regression: fail");
      $finish;
   end
endmodule

// ----- files.f -----
hdl/aarm_pkg.sv
hdl/axis_angle_rotation_matrix.sv
hdl/aarm_checker.sv
tb/sv/axis_angle_rotation_matrix_checker.sv
tb/sv/axis_angle_rotation_matrix_tb.sv
